// ===== design/ftf_pkg.sv =====
// ----------------------------------------------------------------------------
// ftf_pkg
// Shared types, opcodes and the 8x8 font table of the text framebuffer.
// ----------------------------------------------------------------------------
package ftf_pkg;

	// item opcodes
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_SET   = 3'd1;
	localparam logic [2:0] OP_UNSET = 3'd2;
	localparam logic [2:0] OP_CHAR  = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// operations of the byte read-modify-write unit
	typedef enum logic [1:0] {
		RMW_READ,
		RMW_OR,
		RMW_ANDN,
		RMW_ZERO
	} rmw_op_t;

	// one command to the store
	typedef struct packed {
		logic    valid;
		rmw_op_t op;
		logic [7:0] mask;
	} ftf_cmd_t;

	localparam int GLYPH_COUNT      = 37;
	localparam int GLYPH_DIGIT_BASE = 27;

	// blank, A-Z, 0-9; row 0 in the top byte, leftmost pixel in the msb of a row
	localparam logic [63:0] GLYPH_ROM [GLYPH_COUNT] = '{
		64'h0000000000000000,
		64'h3C66667E66666600, 64'h7C66667C66667C00, 64'h3C66606060663C00,
		64'h786C6666666C7800, 64'h7E60607860607E00, 64'h7E60607860606000,
		64'h3C66606E66663C00, 64'h6666667E66666600, 64'h7E18181818187E00,
		64'h1E0C0C0C0C6C3800, 64'h666C7870786C6600, 64'h6060606060607E00,
		64'h63777F6B63636300, 64'h66767E7E6E666600, 64'h3C66666666663C00,
		64'h7C66667C60606000, 64'h3C666666663C0E00, 64'h7C66667C786C6600,
		64'h3C66603C06663C00, 64'h7E18181818181800, 64'h6666666666663C00,
		64'h66666666663C1800, 64'h6363636B7F776300, 64'h66663C183C666600,
		64'h6666663C18181800, 64'h7E060C1830607E00,
		64'h3C666E7666663C00, 64'h1838181818187E00, 64'h3C66060C30607E00,
		64'h3C66061C06663C00, 64'h060E1E667F060600, 64'h7E607C0606663C00,
		64'h3C66607C66663C00, 64'h7E660C1818181800, 64'h3C66663C66663C00,
		64'h3C66663E06663C00
	};

	// character code to glyph number, lower case folded to upper case
	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [7:0] c;
		c = code;
		if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
		if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'd64);
		if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'd48 + 8'(GLYPH_DIGIT_BASE));
		return 6'd0;
	endfunction

	function automatic logic [63:0] glyph_bits(input logic [5:0] g);
		if (g >= 6'(GLYPH_COUNT)) return '0;
		return GLYPH_ROM[g];
	endfunction

endpackage

// ===== design/ftf_store.sv =====
// ----------------------------------------------------------------------------
// ftf_store
// Display byte store with one shared read-modify-write unit: the byte is read
// in the command cycle and merged and written back in the next.
// ----------------------------------------------------------------------------
module ftf_store import ftf_pkg::*; #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ftf_cmd_t          cmd,
	input  logic [ADDR_W-1:0] addr,
	output logic [7:0]        rd_data
);

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_q;
	logic              valid_s1;
	rmw_op_t           op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;
	logic [7:0]        wr_byte;
	logic              wr_en;

	// merge stage
	always_comb begin
		case (op_s1)
			RMW_OR:   wr_byte = rd_q | mask_s1;
			RMW_ANDN: wr_byte = rd_q & ~mask_s1;
			RMW_ZERO: wr_byte = 8'h00;
			default:  wr_byte = rd_q;
		endcase
	end

	assign wr_en = valid_s1 && (op_s1 != RMW_READ);

	// memory read and write-back
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.op != RMW_ZERO) rd_q <= mem[addr];
		if (wr_en) mem[addr_s1] <= wr_byte;
	end

	// command stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= RMW_READ;
			addr_s1  <= '0;
			mask_s1  <= '0;
		end else begin
			valid_s1 <= cmd.valid;
			op_s1    <= cmd.op;
			addr_s1  <= addr;
			mask_s1  <= cmd.mask;
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== design/font_text_framebuffer.sv =====
// ----------------------------------------------------------------------------
// font_text_framebuffer
// Page-organized 1 bit per pixel display store with clear-all, pixel, byte
// read and 8x8 font character drawing operations.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  command  | in        | cmd_valid / cmd_ready | opcode pos_x pos_y char_code
//           |           |                       | string_start byte_index
//  response | out       | rsp_valid / rsp_ready | read_data
//
//  after reset the store is swept to zero, one byte a cycle, over all
//  DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT/8) bytes (1024 by default); clear-all
//  runs the same sweep. a character is drawn one byte read-modify-write per
//  cycle through the shared store port, over the two pages that its rows
//  touch (one page when its top row is on a page boundary), and is dropped
//  when it does not fit; a pixel off the display is dropped, and a read past
//  the end of the store returns zero. a pending response does not block
//  commands; a read waits only for the response register to free up.
module font_text_framebuffer import ftf_pkg::*; #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [2:0]        opcode,
	input  logic signed [8:0] pos_x,
	input  logic signed [8:0] pos_y,
	input  logic [7:0]        char_code,
	input  logic              string_start,
	input  logic [9:0]        byte_index,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [7:0]        read_data
);

	localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int COL_MAX     = 256;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;
	localparam logic [1:0] ST_RDWAIT = 2'd3;

	logic [1:0]        state_q;
	logic [3:0]        step_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] base_q;
	logic [7:0]        mask_q;
	rmw_op_t           op_q;
	logic              is_char_q;
	logic [2:0]        shift_q;
	logic [63:0]       glyph_q;
	logic              oor_q;
	logic signed [9:0] cursor_col_q;
	logic signed [8:0] cursor_row_q;
	logic              rsp_valid_q;
	logic [7:0]        read_data_q;

	logic signed [9:0]  col_eff;
	logic signed [8:0]  row_eff;
	logic signed [10:0] col_sum;
	logic signed [9:0]  col_next;
	logic               char_fit;
	logic               pix_in;
	logic               idx_in;
	logic [8:0]         sel_col;
	logic [8:0]         sel_row;
	logic [15:0]        addr_wide;
	logic [2:0]         step_col;
	logic               step_half;
	logic [7:0]         col_bits;
	logic [7:0]         glyph_row;
	logic [15:0]        shifted;
	logic               last_char;
	ftf_cmd_t           cmd;
	logic [ADDR_W-1:0]  cmd_addr;
	logic [7:0]         rd_data;
	logic               rsp_load;

	// cursor and placement of the item being accepted
	always_comb begin
		col_eff  = string_start ? 10'(pos_x) : cursor_col_q;
		row_eff  = string_start ? pos_y : cursor_row_q;
		col_sum  = 11'(col_eff) + 11'sd8;
		col_next = (col_sum > 11'(COL_MAX)) ? 10'(COL_MAX) : col_sum[9:0];
		char_fit = (col_eff >= 0) && (col_eff <= DISPLAY_WIDTH - 8) &&
			(row_eff >= 0) && (row_eff <= DISPLAY_HEIGHT - 8);
		pix_in   = (pos_x >= 0) && (pos_x < DISPLAY_WIDTH) &&
			(pos_y >= 0) && (pos_y < DISPLAY_HEIGHT);
		idx_in   = {3'b000, byte_index} < 13'(STORE_BYTES);
		sel_col  = (opcode == OP_CHAR) ? col_eff[8:0] : pos_x;
		sel_row  = (opcode == OP_CHAR) ? row_eff : pos_y;
		addr_wide = 16'(sel_row[8:3]) * 16'(DISPLAY_WIDTH) + 16'(sel_col);
	end

	// glyph column of the current step, split over the two pages it touches
	always_comb begin
		step_col  = step_q[3:1];
		step_half = step_q[0];
		col_bits  = '0;
		for (int r = 0; r < 8; r++) begin
			glyph_row   = glyph_q[(7 - r) * 8 +: 8];
			col_bits[r] = glyph_row[3'd7 - step_col];
		end
		shifted   = {8'h00, col_bits} << shift_q;
		last_char = (step_q == 4'd15) || (shift_q == 3'd0 && step_q == 4'd14);
	end

	// command to the store
	always_comb begin
		cmd.valid = (state_q == ST_CLEAR) || (state_q == ST_RUN);
		cmd.op    = (state_q == ST_CLEAR) ? RMW_ZERO : op_q;
		if (is_char_q) begin
			cmd.mask = step_half ? shifted[15:8] : shifted[7:0];
			cmd_addr = base_q + ADDR_W'(step_col) +
				(step_half ? ADDR_W'(DISPLAY_WIDTH) : ADDR_W'(0));
		end else begin
			cmd.mask = mask_q;
			cmd_addr = base_q;
		end
		if (state_q == ST_CLEAR) cmd_addr = clr_q;
	end

	ftf_store #(
		.DEPTH  (STORE_BYTES),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.addr    (cmd_addr),
		.rd_data (rd_data)
	);

	// read result moves into the response register once it is free
	assign rsp_load = (state_q == ST_RDWAIT) && (!rsp_valid_q || rsp_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			step_q       <= '0;
			clr_q        <= '0;
			base_q       <= '0;
			mask_q       <= '0;
			op_q         <= RMW_READ;
			is_char_q    <= 1'b0;
			shift_q      <= '0;
			glyph_q      <= '0;
			oor_q        <= 1'b0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			rsp_valid_q  <= 1'b0;
			read_data_q  <= '0;
		end else begin
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_BYTES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (opcode) inside
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							OP_SET, OP_UNSET: begin
								if (pix_in) begin
									base_q    <= addr_wide[ADDR_W-1:0];
									mask_q    <= 8'h01 << pos_y[2:0];
									op_q      <= (opcode == OP_SET) ? RMW_OR : RMW_ANDN;
									is_char_q <= 1'b0;
									state_q   <= ST_RUN;
								end
							end
							OP_CHAR: begin
								cursor_col_q <= col_next;
								cursor_row_q <= row_eff;
								if (char_fit) begin
									base_q    <= addr_wide[ADDR_W-1:0];
									shift_q   <= row_eff[2:0];
									glyph_q   <= glyph_bits(glyph_index(char_code));
									op_q      <= RMW_OR;
									is_char_q <= 1'b1;
									step_q    <= '0;
									state_q   <= ST_RUN;
								end
							end
							OP_READ: begin
								base_q    <= ADDR_W'(byte_index);
								op_q      <= RMW_READ;
								is_char_q <= 1'b0;
								oor_q     <= !idx_in;
								state_q   <= idx_in ? ST_RUN : ST_RDWAIT;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (is_char_q) begin
						if (last_char) state_q <= ST_IDLE;
						else step_q <= step_q + ((shift_q == 3'd0) ? 4'd2 : 4'd1);
					end else if (op_q == RMW_READ) begin
						state_q <= ST_RDWAIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RDWAIT: begin
					if (rsp_load) begin
						read_data_q <= oor_q ? 8'h00 : rd_data;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;

endmodule

// ===== design/ftf_checker.sv =====
// ----------------------------------------------------------------------------
// ftf_port_checks
// Port-level checks of the text framebuffer, bound to the top level.
// ----------------------------------------------------------------------------
module ftf_port_checks import ftf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [2:0] opcode,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] read_data
);

	// a stalled response holds its data
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data))
		else $error("response dropped or changed while stalled");

	// clear-all sweeps the store, so commands stall while the sweep runs
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && opcode == OP_CLEAR |=>
			!cmd_ready ##1 !cmd_ready ##1 !cmd_ready)
		else $error("command taken during clear sweep");

	// a read always occupies the sequencer after its transfer
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && opcode == OP_READ |=> !cmd_ready)
		else $error("ready stayed high after a read transfer");

	// responses are produced only from the read wait state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(cmd_ready))
		else $error("response appeared while the sequencer was idle");

endmodule

bind font_text_framebuffer ftf_port_checks u_ftf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.opcode    (opcode),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.read_data (read_data)
);
